// ----- hdl/rse_pkg.sv -----
// Shared types and constants for the RPN stack evaluator.
// Used by the front end, the command queue, the stack engine and the top level.
package rse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SADDR_W     = $clog2(STACK_DEPTH);
  localparam int unsigned SDEPTH_W    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request and operator codes on the slave side.
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_MUL      = 2'd1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_POP_EMPTY    = 3'd1,
    ST_FEW_OPERANDS = 3'd2,
    ST_INVALID      = 3'd3,
    ST_FULL         = 3'd4
  } status_e;

  // Command kinds after classification by the front end.
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_ADD,
    CMD_MUL,
    CMD_BAD_OP,
    CMD_BAD_REQ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] value;
  } rse_cmd_t;

endpackage

// ----- hdl/rse_front.sv -----
// Front end: takes request words from the slave port and classifies them.
// Depends on rse_pkg for the command type.
module rse_front import rse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] push_value_i,
  input  logic [1:0]  op_code_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output rse_cmd_t    cmd_o
);

  logic      valid_q, valid_d;
  rse_cmd_t  cmd_q, cmd_d;
  cmd_kind_e kind;

  always_comb begin
    unique case (req_type_i)
      REQ_PUSH:    kind = CMD_PUSH;
      REQ_POP:     kind = CMD_POP;
      REQ_COMPUTE: begin
        if (op_code_i == OP_ADD) begin
          kind = CMD_ADD;
        end else if (op_code_i == OP_MUL) begin
          kind = CMD_MUL;
        end else begin
          kind = CMD_BAD_OP;
        end
      end
      default:     kind = CMD_BAD_REQ;
    endcase
  end

  assign in_ready_o = !valid_q || cmd_ready_i;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (in_valid_i && in_ready_o) begin
      valid_d     = 1'b1;
      cmd_d.kind  = kind;
      cmd_d.value = push_value_i;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ----- hdl/rse_queue.sv -----
// Short command queue between the front end and the stack engine.
// Depends on rse_pkg for the command type and the queue depth.
module rse_queue import rse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  rse_cmd_t wr_cmd_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output rse_cmd_t rd_cmd_o
);

  rse_cmd_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign wr_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ----- hdl/rse_engine.sv -----
// Stack engine: top of stack in a register, the entries below it in a memory,
// saturating Q16.16 add and multiply, and the result register. Depends on rse_pkg.
module rse_engine import rse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  rse_cmd_t            cmd_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [2:0]          status_o,
  output logic [31:0]         top_value_o,
  output logic                top_valid_o,
  output logic [SDEPTH_W-1:0] stack_depth_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_FILL,
    S_OPERAND,
    S_MUL_DONE
  } state_e;

  state_e               state_q, state_d;
  logic signed [31:0]   top_q, top_d;
  logic [SDEPTH_W-1:0]  depth_q, depth_d;
  logic                 mul_q, mul_d;
  logic signed [63:0]   prod_q, prod_d;

  logic                 res_valid_q, res_valid_d;
  logic [2:0]           res_status_q, res_status_d;
  logic [31:0]          res_top_q, res_top_d;
  logic                 res_tvalid_q, res_tvalid_d;
  logic [SDEPTH_W-1:0]  res_depth_q, res_depth_d;

  logic [31:0]          mem_q [STACK_DEPTH];
  logic signed [31:0]   rdata_q;
  logic                 wr_en;
  logic [SDEPTH_W-1:0]  depth_m1, depth_m2;
  logic [SADDR_W-1:0]   wr_addr, rd_addr;

  logic                 out_free, take, emit, is_full;
  status_e              status;
  logic signed [32:0]   sum;
  logic signed [31:0]   sum_sat;
  logic signed [63:0]   rounded;
  logic signed [31:0]   mul_sat;

  assign depth_m1 = depth_q - 1'b1;
  assign depth_m2 = depth_q - 2'd2;
  assign wr_addr  = depth_m1[SADDR_W-1:0];
  assign rd_addr  = depth_m2[SADDR_W-1:0];
  assign is_full  = (depth_q == SDEPTH_W'(STACK_DEPTH));

  assign out_free    = !res_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;

  // The sign bits of a 33-bit sum disagree only on overflow.
  assign sum = {top_q[31], top_q} + {rdata_q[31], rdata_q};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Round to nearest with ties upward, then the arithmetic shift floors.
  assign rounded = (prod_q + 64'sd32768) >>> 16;
  always_comb begin
    if (rounded > 64'sh0000_0000_7fff_ffff) begin
      mul_sat = 32'sh7fff_ffff;
    end else if (rounded < -64'sh0000_0000_8000_0000) begin
      mul_sat = 32'sh8000_0000;
    end else begin
      mul_sat = rounded[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    top_d   = top_q;
    depth_d = depth_q;
    mul_d   = mul_q;
    prod_d  = prod_q;
    wr_en   = 1'b0;
    emit    = 1'b0;
    status  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (cmd_i.kind)
            CMD_PUSH: begin
              emit = 1'b1;
              if (is_full) begin
                status = ST_FULL;
              end else begin
                wr_en   = (depth_q != '0);
                top_d   = cmd_i.value;
                depth_d = depth_q + 1'b1;
              end
            end
            CMD_POP: begin
              if (depth_q == '0) begin
                emit   = 1'b1;
                status = ST_POP_EMPTY;
              end else if (depth_q == SDEPTH_W'(1)) begin
                emit    = 1'b1;
                depth_d = '0;
              end else begin
                state_d = S_POP_FILL;
              end
            end
            CMD_ADD, CMD_MUL: begin
              if (depth_q < SDEPTH_W'(2)) begin
                emit   = 1'b1;
                status = ST_FEW_OPERANDS;
              end else begin
                mul_d   = (cmd_i.kind == CMD_MUL);
                state_d = S_OPERAND;
              end
            end
            CMD_BAD_OP: begin
              emit   = 1'b1;
              status = (depth_q == '0) ? ST_FEW_OPERANDS : ST_INVALID;
            end
            default: begin
              emit   = 1'b1;
              status = ST_INVALID;
            end
          endcase
        end
      end
      S_POP_FILL: begin
        emit    = 1'b1;
        top_d   = rdata_q;
        depth_d = depth_m1;
        state_d = S_IDLE;
      end
      S_OPERAND: begin
        if (mul_q) begin
          prod_d  = top_q * rdata_q;
          state_d = S_MUL_DONE;
        end else begin
          emit    = 1'b1;
          top_d   = sum_sat;
          depth_d = depth_m1;
          state_d = S_IDLE;
        end
      end
      S_MUL_DONE: begin
        emit    = 1'b1;
        top_d   = mul_sat;
        depth_d = depth_m1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d  = res_valid_q;
    res_status_d = res_status_q;
    res_top_d    = res_top_q;
    res_tvalid_d = res_tvalid_q;
    res_depth_d  = res_depth_q;
    if (emit) begin
      res_valid_d  = 1'b1;
      res_status_d = status;
      res_top_d    = (depth_d != '0) ? top_d : '0;
      res_tvalid_d = (depth_d != '0);
      res_depth_d  = depth_d;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      depth_q      <= '0;
      top_q        <= '0;
      mul_q        <= 1'b0;
      prod_q       <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= '0;
      res_top_q    <= '0;
      res_tvalid_q <= 1'b0;
      res_depth_q  <= '0;
    end else begin
      state_q      <= state_d;
      depth_q      <= depth_d;
      top_q        <= top_d;
      mul_q        <= mul_d;
      prod_q       <= prod_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_top_q    <= res_top_d;
      res_tvalid_q <= res_tvalid_d;
      res_depth_q  <= res_depth_d;
    end
  end

  // The memory holds every entry below the top; a push spills the old top.
  // The entry under the top is read into rdata_q every cycle, so a refill uses a registered value.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= top_q;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign top_value_o   = res_top_q;
  assign top_valid_o   = res_tvalid_q;
  assign stack_depth_o = res_depth_q;

endmodule

// ----- hdl/rpn_stack_evaluator_top.sv -----
// RPN stack evaluator top level: front end, command queue and stack engine.
// An accepted word passes the front end register and a queue slot to the engine; a
// pop that refills the top goes through S_POP_FILL, an add through S_OPERAND and a
// multiply through S_OPERAND and S_MUL_DONE. The engine takes no new word until it
// is back in S_IDLE with its result register free. Reset clears the depth and all
// valid flags; the value memory is not cleared and needs no time after reset.
module rpn_stack_evaluator_top import rse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [3:0]  s_axis_tuser,   // [1:0] req_type, [3:2] op_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] top_value, [32] top_valid,
                                      // [37:33] stack_depth, [39:38] zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  logic                fq_valid, fq_ready;
  rse_cmd_t            fq_cmd;
  logic                qe_valid, qe_ready;
  rse_cmd_t            qe_cmd;
  logic [31:0]         top_value;
  logic                top_valid;
  logic [SDEPTH_W-1:0] stack_depth;

  rse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser[1:0]),
    .push_value_i (s_axis_tdata),
    .op_code_i    (s_axis_tuser[3:2]),
    .cmd_valid_o  (fq_valid),
    .cmd_ready_i  (fq_ready),
    .cmd_o        (fq_cmd)
  );

  rse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_cmd_i   (fq_cmd),
    .rd_valid_o (qe_valid),
    .rd_ready_i (qe_ready),
    .rd_cmd_o   (qe_cmd)
  );

  rse_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (qe_valid),
    .cmd_ready_o   (qe_ready),
    .cmd_i         (qe_cmd),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .status_o      (m_axis_tuser),
    .top_value_o   (top_value),
    .top_valid_o   (top_valid),
    .stack_depth_o (stack_depth)
  );

  assign m_axis_tdata = {{(40 - 33 - SDEPTH_W){1'b0}}, stack_depth, top_valid, top_value};

endmodule
